// ===== design/wpts_pkg.sv =====
`timescale 1ns / 1ps

package wpts_pkg;

    // Width of the internal offset and index counters.
    localparam int OFFSET_BITS = 24;
    // Width of the offset and index fields on the result port.
    localparam int TOKEN_W = 24;
    // Depth of the job queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    // Input command codes.
    localparam logic CMD_TEXT  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Token kinds.
    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_PUNCT = 1'b1;

    // Byte classes.
    localparam logic [1:0] CLS_SPACE = 2'd0;
    localparam logic [1:0] CLS_ALNUM = 2'd1;
    localparam logic [1:0] CLS_OTHER = 2'd2;

    // Character constants.
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UZ   = 8'h5A;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic                   flush;      // end of text: clear the back's counters
        logic                   word_emit;  // a pending word ends here
        logic                   punct_emit; // a punctuation token follows
        logic                   sat_set;    // the byte offset saturated on this byte
        logic [OFFSET_BITS-1:0] word_start;
        logic [OFFSET_BITS-1:0] word_end;   // also the punctuation start
        logic [OFFSET_BITS-1:0] punct_end;
        logic [7:0]             punct_byte;
    } job_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic nonempty;
    } qstat_t;

    // Class of one text byte.
    function automatic logic [1:0] classify(input logic [7:0] b);
        logic [1:0] c;
        if (b == CH_TAB || b == CH_CR || b == CH_LF || b == CH_SP)
            c = CLS_SPACE;
        else if ((b >= CH_0 && b <= CH_9) || (b >= CH_LA && b <= CH_LZ)
                 || (b >= CH_UA && b <= CH_UZ))
            c = CLS_ALNUM;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    // Fit an internal offset or index to the result field width.
    function automatic logic [TOKEN_W-1:0] fit_token(input logic [OFFSET_BITS-1:0] v);
        return TOKEN_W'(v);
    endfunction

endpackage

// ===== design/wpts_front.sv =====
`timescale 1ns / 1ps

module wpts_front
    import wpts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] char_code,
    input  qstat_t     qstat,
    output logic       push,
    output job_t       push_job
);

    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] wstart_reg, wstart_next;
    logic                   in_word_reg, in_word_next;

    logic                   accept;
    logic                   need;
    logic                   at_max;
    logic [OFFSET_BITS-1:0] end_off;
    logic [1:0]             cls;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;
    assign push     = accept && need;

    // Classify the byte, track the offset and the pending word, and build a job.
    always_comb
    begin
        offset_next  = offset_reg;
        wstart_next  = wstart_reg;
        in_word_next = in_word_reg;
        cls          = classify(char_code);
        at_max       = (offset_reg == OFF_MAX);
        end_off      = at_max ? offset_reg : offset_reg + 1'b1;
        need         = 1'b0;

        push_job            = '0;
        push_job.word_start = wstart_reg;
        push_job.word_end   = offset_reg;
        push_job.punct_end  = end_off;
        push_job.punct_byte = char_code;

        if (cmd == CMD_FLUSH)
        begin
            push_job.flush     = 1'b1;
            push_job.word_emit = in_word_reg;
            need               = 1'b1;
            if (accept)
            begin
                offset_next  = '0;
                wstart_next  = '0;
                in_word_next = 1'b0;
            end
        end
        else
        begin
            push_job.sat_set = at_max;
            if (cls == CLS_ALNUM)
            begin
                need = at_max;
            end
            else
            begin
                push_job.word_emit  = in_word_reg;
                push_job.punct_emit = (cls == CLS_OTHER);
                need = at_max || in_word_reg || (cls == CLS_OTHER);
            end
            if (accept)
            begin
                offset_next = end_off;
                if (cls == CLS_ALNUM)
                begin
                    if (!in_word_reg)
                    begin
                        wstart_next  = offset_reg;
                        in_word_next = 1'b1;
                    end
                end
                else
                begin
                    in_word_next = 1'b0;
                end
            end
        end
    end

    // Front state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            wstart_reg  <= '0;
            in_word_reg <= 1'b0;
        end
        else
        begin
            offset_reg  <= offset_next;
            wstart_reg  <= wstart_next;
            in_word_reg <= in_word_next;
        end
    end

endmodule

// ===== design/wpts_queue.sv =====
`timescale 1ns / 1ps

module wpts_queue
    import wpts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   push_job,
    input  logic   pop,
    output job_t   head,
    output qstat_t qstat
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head           = slot_reg[rptr_reg];
    assign qstat.full     = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.nonempty = (count_reg != '0);

    // Pointer and fill count updates.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Job storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_job;
    end

endmodule

// ===== design/wpts_back.sv =====
`timescale 1ns / 1ps

module wpts_back
    import wpts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  job_t               head,
    input  qstat_t             qstat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TOKEN_W-1:0] token_start,
    output logic [TOKEN_W-1:0] token_end,
    output logic [TOKEN_W-1:0] token_index,
    output logic               token_kind,
    output logic [7:0]         punct_byte,
    output logic               overflow,
    output logic               last_of_run
);

    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic                   sat_reg, sat_next;
    logic                   phase_reg, phase_next;
    logic                   ovalid_reg, ovalid_next;
    logic [TOKEN_W-1:0]     start_reg, start_next;
    logic [TOKEN_W-1:0]     end_reg, end_next;
    logic [TOKEN_W-1:0]     index_reg, index_next;
    logic                   kind_reg, kind_next;
    logic [7:0]             pbyte_reg, pbyte_next;
    logic                   ovf_reg, ovf_next;
    logic                   last_reg, last_next;

    logic                   advance;
    logic                   emit_word;
    logic                   emit_punct;
    logic                   step;
    logic                   sat_in;
    logic                   count_max;

    assign out_valid   = ovalid_reg;
    assign token_start = start_reg;
    assign token_end   = end_reg;
    assign token_index = index_reg;
    assign token_kind  = kind_reg;
    assign punct_byte  = pbyte_reg;
    assign overflow    = ovf_reg;
    assign last_of_run = last_reg;

    // Work off the head job: one token per cycle while the output is not stalled, counters in order.
    always_comb
    begin
        count_next  = count_reg;
        sat_next    = sat_reg;
        phase_next  = phase_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        index_next  = index_reg;
        kind_next   = kind_reg;
        pbyte_next  = pbyte_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;

        advance    = !ovalid_reg || !out_stall;
        emit_word  = head.word_emit && !phase_reg;
        emit_punct = head.punct_emit && (phase_reg || !head.word_emit);
        step       = qstat.nonempty && (!(emit_word || emit_punct) || advance);
        pop        = step && !(emit_word && head.punct_emit);
        sat_in     = sat_reg || head.sat_set;
        count_max  = (count_reg == OFF_MAX);

        ovalid_next = advance ? (step && (emit_word || emit_punct)) : ovalid_reg;

        if (step)
        begin
            if (emit_word || emit_punct)
            begin
                count_next = count_max ? count_reg : count_reg + 1'b1;
                sat_next   = sat_in || count_max;
                index_next = fit_token(count_reg);
                ovf_next   = sat_in || count_max;
                if (emit_word)
                begin
                    start_next = fit_token(head.word_start);
                    end_next   = fit_token(head.word_end);
                    kind_next  = KIND_WORD;
                    pbyte_next = '0;
                    last_next  = !head.punct_emit;
                end
                else
                begin
                    start_next = fit_token(head.word_end);
                    end_next   = fit_token(head.punct_end);
                    kind_next  = KIND_PUNCT;
                    pbyte_next = head.punct_byte;
                    last_next  = 1'b1;
                end
            end
            else
            begin
                sat_next = sat_in;
            end
            phase_next = emit_word && head.punct_emit;
            if (head.flush)
            begin
                count_next = '0;
                sat_next   = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sat_reg    <= 1'b0;
            phase_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            sat_reg    <= sat_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        index_reg <= index_next;
        kind_reg  <= kind_next;
        pbyte_reg <= pbyte_next;
        ovf_reg   <= ovf_next;
        last_reg  <= last_next;
    end

endmodule

// ===== design/word_punct_token_splitter.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  cmd, char_code
// result    out        out_valid / out_stall token_start, token_end, token_index,
//                                           token_kind, punct_byte, overflow, last_of_run
//
// One byte is taken per cycle while in_stall is low; the front classifies it in that cycle
// and queues a job when the byte needs one. The back gives one token per cycle while out_stall
// is low, so a byte that ends a word and is punctuation yields two tokens from one job;
// the four-entry job queue absorbs this. A result passes the queue write, then the output
// register, after its byte's transfer.
// Reset clears the offsets, the word state, the counters and the queue.
// in_stall rises only when the queue is full; out_stall holds the output register.

module word_punct_token_splitter
    import wpts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [TOKEN_W-1:0] token_start,
    output logic [TOKEN_W-1:0] token_end,
    output logic [TOKEN_W-1:0] token_index,
    output logic               token_kind,
    output logic [7:0]         punct_byte,
    output logic               overflow,
    output logic               last_of_run
);

    qstat_t qstat;
    logic   push;
    job_t   push_job;
    logic   pop;
    job_t   head;

    // Classification and offset tracking.
    wpts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .char_code (char_code),
        .qstat     (qstat),
        .push      (push),
        .push_job  (push_job)
    );

    // Job queue between the two halves.
    wpts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // Token numbering and result output.
    wpts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_start (token_start),
        .token_end   (token_end),
        .token_index (token_index),
        .token_kind  (token_kind),
        .punct_byte  (punct_byte),
        .overflow    (overflow),
        .last_of_run (last_of_run)
    );

endmodule
